>>> design/sptb_pkg.sv
// sptb_pkg: constants, command codes and register map for sparse_positions_to_bitmap
// used by the item interfaces and the top level
package sptb_pkg;

    localparam int WORDS   = 256;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int IDX_W   = $clog2(WORDS);
    localparam int POS_W   = 16;
    localparam int WIDX_W  = 8;
    localparam int CMD_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [0:0] {
        REG_FIRST_POSITION = 1'b0
    } t_reg;

endpackage

>>> design/sptb_in_if.sv
// sptb_in_if: input item channel (command, position, word_index)
// depends on sptb_pkg for field widths
interface sptb_in_if;
    logic                        valid;
    logic                        ready;
    logic [sptb_pkg::CMD_W-1:0]  command;
    logic [sptb_pkg::POS_W-1:0]  position;
    logic [sptb_pkg::WIDX_W-1:0] word_index;

    modport source (output valid, output command, output position, output word_index,
                    input ready);
    modport sink   (input valid, input command, input position, input word_index,
                    output ready);
endinterface

>>> design/sptb_out_if.sv
// sptb_out_if: result item channel (read_data, was_new, in_range)
// depends on sptb_pkg for field widths
interface sptb_out_if;
    logic                        valid;
    logic                        ready;
    logic [sptb_pkg::WORD_W-1:0] read_data;
    logic                        was_new;
    logic                        in_range;

    modport source (output valid, output read_data, output was_new, output in_range,
                    input ready);
    modport sink   (input valid, input read_data, input was_new, input in_range,
                    output ready);
endinterface

>>> design/sptb_ram.sv
// sptb_ram: generic single write port, single read port ram with registered read
// no dependencies
module sptb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/sparse_positions_to_bitmap.sv
// sparse_positions_to_bitmap: dense bit vector built from a stream of bit positions
// depends on sptb_pkg, sptb_in_if, sptb_out_if and sptb_ram
//
// usage:
//   i_item carries commands: clear the vector, add a position, read one 64-bit word.
//   every item gives exactly one result item on o_result.
//   first_position (apb register 0) is subtracted from each added position;
//   write it only while no item is in flight.
// timing:
//   an item's word is read from the bitmap ram at the edge that takes it in, and its
//   result moves into the output register when the ram stage passes it on.
//   the read-modify-write runs through one ram read port and one write port with
//   forwarding of the last written word: one item per cycle while o_result is ready.
// reset:
//   all per-word valid bits clear at once, so the vector reads as empty right away;
//   the ram itself is never cleared and no reset sweep is needed.
// backpressure:
//   when o_result is stalled the pipeline holds; i_item.ready drops only while the
//   ram stage holds an item that cannot move into the output register.
module sparse_positions_to_bitmap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sptb_in_if.sink                       i_item,
    sptb_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sptb_pkg::PADDR_W-1:0]  paddr,
    input  logic [sptb_pkg::PDATA_W-1:0]  pwdata,
    output logic [sptb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import sptb_pkg::*;

    logic [POS_W-1:0]  r_first;

    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [IDX_W-1:0]  r_s1_addr;
    logic [BIT_W-1:0]  r_s1_bit;
    logic              r_s1_ok;

    logic              r_wb_valid;
    logic [IDX_W-1:0]  r_wb_addr;
    logic [WORD_W-1:0] r_wb_data;

    logic [WORDS-1:0]  r_written;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;
    logic              r_out_new;
    logic              r_out_range;

    logic              cfg_wr;
    logic              accept;
    logic              out_free;
    logic              s1_fire;
    logic [POS_W:0]    diff;
    logic [POS_W-1:0]  w_pos;
    logic [31:0]       w_word;
    logic [31:0]       w_ridx;
    logic              add_ok;
    logic              read_ok;
    logic [IDX_W-1:0]  rd_addr;
    logic [BIT_W-1:0]  bit_sel;
    logic              cmd_ok;

    logic [WORD_W-1:0] ram_rdata;
    logic              hit;
    logic [WORD_W-1:0] old_word;
    logic [WORD_W-1:0] bit_mask;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] n_data;
    logic              n_new;
    logic              n_range;

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FIRST_POSITION);
    assign prdata = (paddr[2] == REG_FIRST_POSITION) ?
                    {{(PDATA_W-POS_W){1'b0}}, r_first} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
        end else if (cfg_wr) begin
            r_first <= pwdata[POS_W-1:0];
        end
    end

    // handshake
    assign out_free       = !r_out_valid || o_result.ready;
    assign s1_fire        = r_s1_valid && out_free;
    assign i_item.ready   = !r_s1_valid || out_free;
    assign accept         = i_item.valid && i_item.ready;

    // offset and range checks at entry
    assign diff    = {1'b0, i_item.position} - {1'b0, r_first};
    assign w_pos   = diff[POS_W-1:0];
    assign w_word  = 32'(w_pos) >> BIT_W;
    assign w_ridx  = 32'(i_item.word_index);
    assign add_ok  = !diff[POS_W] && (w_word < 32'(WORDS));
    assign read_ok = w_ridx < 32'(WORDS);

    always_comb begin
        rd_addr = w_ridx[IDX_W-1:0];
        bit_sel = w_pos[BIT_W-1:0];
        cmd_ok  = 1'b0;
        unique case (i_item.command)
            CMD_ADD: begin
                rd_addr = w_word[IDX_W-1:0];
                cmd_ok  = add_ok;
            end
            CMD_READ: begin
                cmd_ok  = read_ok;
            end
            default: begin
                cmd_ok  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd  <= i_item.command;
            r_s1_addr <= rd_addr;
            r_s1_bit  <= bit_sel;
            r_s1_ok   <= cmd_ok;
        end
    end

    sptb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // read-modify-write stage
    assign hit      = r_wb_valid && (r_wb_addr == r_s1_addr);
    assign old_word = hit ? r_wb_data : (r_written[r_s1_addr] ? ram_rdata : '0);
    assign bit_mask = WORD_W'(1) << r_s1_bit;
    assign wr_data  = old_word | bit_mask;

    always_comb begin
        wr_en   = 1'b0;
        n_data  = '0;
        n_new   = 1'b0;
        n_range = 1'b0;
        case (r_s1_cmd)
            CMD_ADD: begin
                if (r_s1_ok) begin
                    wr_en   = s1_fire;
                    n_new   = !old_word[r_s1_bit];
                    n_range = 1'b1;
                end
            end
            CMD_READ: begin
                if (r_s1_ok) begin
                    n_data = old_word;
                end
            end
            default: begin
                n_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_wb_valid <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1_cmd == CMD_CLEAR) begin
                r_written  <= '0;
                r_wb_valid <= 1'b0;
            end else begin
                if (wr_en) begin
                    r_written[r_s1_addr] <= 1'b1;
                end
                r_wb_valid <= wr_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_addr <= r_s1_addr;
            r_wb_data <= wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data  <= n_data;
            r_out_new   <= n_new;
            r_out_range <= n_range;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.read_data = r_out_data;
    assign o_result.was_new   = r_out_new;
    assign o_result.in_range  = r_out_range;
endmodule

>>> tb/tb_sparse_positions_to_bitmap.sv
`timescale 1ns / 1ps
// tb_sparse_positions_to_bitmap: self-checking bench for the position-to-bitmap block
// drives a directed table and random command streams, predicts every result item
// depends on sptb_pkg, sptb_in_if, sptb_out_if and the sparse_positions_to_bitmap rtl
module tb_sparse_positions_to_bitmap;
    import sptb_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_FIRST_POSITION = PADDR_W'(4 * int'(REG_FIRST_POSITION));
    localparam int unsigned        VECTOR_BITS = WORDS * WORD_W;
    localparam int                 N_DIRECTED = 29;
    localparam int                 N_PHASES = 6;
    localparam int                 PHASE_ITEMS = 170;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              was_new;
        logic              in_range;
    } t_bitmap_result;

    typedef struct packed {
        logic              is_cfg;
        logic [POS_W-1:0]  cfg_value;
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [WIDX_W-1:0] widx;
        logic              has_exp;
        t_bitmap_result    exp;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    sptb_in_if  item_if ();
    sptb_out_if result_if ();

    sparse_positions_to_bitmap dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    // predicted bitmap state
    logic [WORD_W-1:0] bitmap_words [WORDS];
    bit                word_valid [WORDS];
    bit                ram_touched [WORDS];
    int unsigned       touched_words [$];
    int unsigned       recent_offsets [$];
    logic [POS_W-1:0]  first_pos_q = '0;

    t_bitmap_result    awaited_results [$];
    t_bitmap_result    oldest_result;
    int unsigned       mismatch_count = 0;
    bit                no_idle = 1'b0;
    int unsigned       holdoff_request = 0;
    int unsigned       holdoff_left = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{1'b0, 16'h0, CMD_ADD,    16'd0,     8'd0,   1'b1, '{64'h0, 1'b1, 1'b1}},
        '{1'b0, 16'h0, CMD_ADD,    16'd0,     8'd0,   1'b1, '{64'h0, 1'b0, 1'b1}},
        '{1'b0, 16'h0, CMD_ADD,    16'd16383, 8'hff,  1'b1, '{64'h0, 1'b1, 1'b1}},
        '{1'b0, 16'h0, CMD_ADD,    16'd16384, 8'h0,   1'b1, '{64'h0, 1'b0, 1'b0}},
        '{1'b0, 16'h0, CMD_ADD,    16'hffff,  8'hff,  1'b1, '{64'h0, 1'b0, 1'b0}},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd0,   1'b1, '{64'h1, 1'b0, 1'b0}},
        '{1'b0, 16'h0, CMD_READ,   16'hffff,  8'd255, 1'b1,
          '{64'h8000_0000_0000_0000, 1'b0, 1'b0}},
        '{1'b0, 16'h0, CMD_ADD,    16'd63,    8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'd64,    8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_UNUSED, 16'hffff,  8'hff,  1'b1, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd1,   1'b0, '0},
        '{1'b0, 16'h0, CMD_CLEAR,  16'hffff,  8'hff,  1'b1, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd0,   1'b1, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'd5,     8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'd10922, 8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'd5461,  8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd170, 1'b0, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd85,  1'b0, '0},
        '{1'b1, 16'hffff, CMD_CLEAR, 16'h0,   8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'hfffe,  8'd0,   1'b1, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'hffff,  8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'h0,     8'd0,   1'b1, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd0,   1'b0, '0},
        '{1'b1, 16'hc000, CMD_CLEAR, 16'h0,   8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'hbfff,  8'd0,   1'b1, '0},
        '{1'b0, 16'h0, CMD_ADD,    16'hffff,  8'd0,   1'b0, '0},
        '{1'b0, 16'h0, CMD_READ,   16'h0,     8'd255, 1'b0, '0}
    };

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] exp_val,
                                   input logic [WORD_W-1:0] got_val);
        $display("mismatch %s: expected %h got %h at %0t", what, exp_val, got_val, $realtime);
        mismatch_count++;
    endtask

    function automatic t_bitmap_result apply_to_bitmap(input logic [CMD_W-1:0] cmd,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic [WIDX_W-1:0] widx);
        t_bitmap_result    res;
        int unsigned       offs;
        int unsigned       word_sel;
        logic [WORD_W-1:0] bit_sel;
        logic [WORD_W-1:0] old_word;
        res = '0;
        case (cmd)
            CMD_CLEAR: begin
                foreach (word_valid[i]) word_valid[i] = 1'b0;
            end
            CMD_ADD: begin
                if (pos >= first_pos_q) begin
                    offs = pos - first_pos_q;
                    if (offs < VECTOR_BITS) begin
                        word_sel = offs >> BIT_W;
                        bit_sel = 64'd1 << (offs % WORD_W);
                        old_word = word_valid[word_sel] ? bitmap_words[word_sel] : '0;
                        res.in_range = 1'b1;
                        res.was_new = ((old_word & bit_sel) == '0);
                        bitmap_words[word_sel] = old_word | bit_sel;
                        word_valid[word_sel] = 1'b1;
                        if (!ram_touched[word_sel]) begin
                            ram_touched[word_sel] = 1'b1;
                            touched_words.push_back(word_sel);
                        end
                    end
                end
            end
            CMD_READ: begin
                if (widx < WORDS && word_valid[widx])
                    res.read_data = bitmap_words[widx];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [WIDX_W-1:0] widx, input logic has_exp,
                                input t_bitmap_result typed);
        t_bitmap_result predicted;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99, 0) < 17) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.command    <= cmd;
        item_if.position   <= pos;
        item_if.word_index <= widx;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        predicted = apply_to_bitmap(cmd, pos, widx);
        awaited_results.push_back(has_exp ? typed : predicted);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_first_position(input logic [POS_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FIRST_POSITION;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        first_pos_q = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== PDATA_W'(value))
            report_mismatch("first_position readback", WORD_W'(value), WORD_W'(prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic make_random_command(output logic [CMD_W-1:0] cmd,
                                       output logic [POS_W-1:0] pos,
                                       output logic [WIDX_W-1:0] widx);
        int unsigned sel;
        int unsigned choice;
        int unsigned max_w;
        int unsigned w;
        sel  = $urandom_range(99, 0);
        pos  = POS_W'($urandom);
        widx = WIDX_W'($urandom);
        max_w = (65535 - first_pos_q < VECTOR_BITS - 1) ? 65535 - first_pos_q : VECTOR_BITS - 1;
        if (sel < 3) begin
            cmd = CMD_CLEAR;
        end else if (sel < 5) begin
            cmd = CMD_UNUSED;
        end else if (sel < 35 && touched_words.size() != 0) begin
            cmd  = CMD_READ;
            widx = WIDX_W'(touched_words[$urandom_range(touched_words.size() - 1, 0)]);
        end else if (sel >= 35 && sel < 45) begin
            cmd = CMD_ADD;
            choice = $urandom_range(2, 0);
            if (choice == 0 && first_pos_q != 0)
                pos = POS_W'($urandom_range(first_pos_q - 1, 0));
            else if (choice == 1 && first_pos_q + VECTOR_BITS <= 65535)
                pos = POS_W'($urandom_range(65535, first_pos_q + VECTOR_BITS));
        end else begin
            cmd = CMD_ADD;
            w = $urandom_range(max_w, 0);
            // revisit an earlier offset to hit duplicates
            if (recent_offsets.size() != 0 && $urandom_range(99, 0) < 30) begin
                choice = recent_offsets[$urandom_range(recent_offsets.size() - 1, 0)];
                if (choice <= max_w) w = choice;
            end
            recent_offsets.push_back(w);
            if (recent_offsets.size() > 32) void'(recent_offsets.pop_front());
            pos = POS_W'(first_pos_q + w);
        end
    endtask

    initial begin
        o_result_ready_init();
    end

    task automatic o_result_ready_init();
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_request != 0) begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left != 0) begin
                result_if.ready <= 1'b0;
                holdoff_left--;
            end else begin
                result_if.ready <= no_idle || ($urandom_range(99, 0) >= 17);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result read_data", '0, result_if.read_data);
            end else begin
                oldest_result = awaited_results.pop_front();
                if (result_if.read_data !== oldest_result.read_data)
                    report_mismatch("read_data", oldest_result.read_data, result_if.read_data);
                if (result_if.was_new !== oldest_result.was_new)
                    report_mismatch("was_new", WORD_W'(oldest_result.was_new),
                                    WORD_W'(result_if.was_new));
                if (result_if.in_range !== oldest_result.in_range)
                    report_mismatch("in_range", WORD_W'(oldest_result.in_range),
                                    WORD_W'(result_if.in_range));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[sparse_positions_to_bitmap] ERROR");
        $finish;
    end

    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [WIDX_W-1:0] widx;
        logic [POS_W-1:0]  phase_offsets [N_PHASES];
        phase_offsets = '{16'h0000, 16'hffff, 16'hc000, 16'h0000, 16'h0001, 16'h0000};
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        item_if.valid      = 1'b0;
        item_if.command    = '0;
        item_if.position   = '0;
        item_if.word_index = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_results_drained();
                write_first_position(directed_rows[i].cfg_value);
            end else begin
                send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].widx,
                             directed_rows[i].has_exp, directed_rows[i].exp);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_results_drained();
            if (p == 3 || p == 5)
                write_first_position(POS_W'($urandom_range(65534, 1)));
            else
                write_first_position(phase_offsets[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                no_idle = (p == 0 && k >= 30 && k < 130);
                if (p == 3 && k == 50) holdoff_request = 60;
                if (p == 2 && k == 90) wait_results_drained();
                make_random_command(cmd, pos, widx);
                send_command(cmd, pos, widx, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        wait_results_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("[sparse_positions_to_bitmap] OK");
        else
            $display("[sparse_positions_to_bitmap] ERROR");
        $finish;
    end

endmodule
